[hw/rtl/ordl_pkg.sv]
// ordl_pkg: shared constants, field widths and command codes of the ordered entry list
// no dependencies
`default_nettype none

package ordl_pkg;

    localparam int CAPACITY_DEF = 512;
    localparam int RANKS_DEF    = 13;
    localparam int GROUPS_DEF   = 4;

    localparam int CMD_W      = 3;
    localparam int RANK_W     = 4;
    localparam int GROUP_W    = 2;
    localparam int POS_W      = 9;
    localparam int COUNT_W    = 10;
    localparam int DECK_W     = 4;
    localparam int ENTRY_W    = RANK_W + GROUP_W;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [DECK_W-1:0] DECK_RESET = 4'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL   = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_READ   = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_REMOVE = 3'd5
    } command_t;

    function automatic logic [ENTRY_W-1:0] pack_entry(
        input logic [RANK_W-1:0]  rank,
        input logic [GROUP_W-1:0] group
    );
        return {group, rank};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ordl_in_if.sv]
// ordl_in_if: command channel, valid/ready handshake with command payload
// depends on ordl_pkg
`default_nettype none

interface ordl_in_if;
    logic                         valid;
    logic                         ready;
    logic [ordl_pkg::CMD_W-1:0]   command;
    logic [ordl_pkg::RANK_W-1:0]  entry_rank;
    logic [ordl_pkg::GROUP_W-1:0] entry_group;
    logic [ordl_pkg::POS_W-1:0]   position;

    modport source (output valid, command, entry_rank, entry_group, position, input ready);
    modport sink   (input valid, command, entry_rank, entry_group, position, output ready);
endinterface

`default_nettype wire

[hw/rtl/ordl_out_if.sv]
// ordl_out_if: result channel, valid/ready handshake with result payload
// depends on ordl_pkg
`default_nettype none

interface ordl_out_if;
    logic                         valid;
    logic                         ready;
    logic [ordl_pkg::RANK_W-1:0]  out_rank;
    logic [ordl_pkg::GROUP_W-1:0] out_group;
    logic                         found;
    logic [ordl_pkg::POS_W-1:0]   found_position;
    logic [ordl_pkg::COUNT_W-1:0] count_after;
    logic                         error;

    modport source (output valid, out_rank, out_group, found, found_position, count_after,
                     error, input ready);
    modport sink   (input valid, out_rank, out_group, found, found_position, count_after,
                     error, output ready);
endinterface

`default_nettype wire

[hw/rtl/ordl_ram.sv]
// ordl_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ordl_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/ordered_entry_list_with_compaction.sv]
// ordered_entry_list_with_compaction: ordered list in one ram with fill, clear, append, read,
// find and compacting remove; apb register for the fill deck count
// depends on ordl_pkg, ordl_in_if, ordl_out_if, ordl_ram
//
// channel   direction  handshake        payload
// cmd_in    in         valid/ready      command, entry_rank, entry_group, position
// res_out   out        valid/ready      out_rank, out_group, found, found_position,
//                                       count_after, error
// apb       in         psel/penable     deck_count at any address (paddr not decoded), pready always high
//
// one command at a time, taken only while idle; every result goes through one output
// register, so the next command is taken while a result waits
// clear, append and refused commands go straight to the result; read fetches one entry,
// find scans entries until a match or the end, remove moves each later entry down one
// place, fill writes entries and flags an error when cut at capacity
// asynchronous reset empties the list and sets deck_count to 1; no clearing pass
`default_nettype none

module ordered_entry_list_with_compaction #(
    parameter int CAPACITY        = ordl_pkg::CAPACITY_DEF,
    parameter int RANKS_PER_GROUP = ordl_pkg::RANKS_DEF,
    parameter int GROUPS          = ordl_pkg::GROUPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ordl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ordl_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [ordl_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    ordl_in_if.sink                              cmd_in,
    ordl_out_if.source                           res_out
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ordl_pkg::POS_W) ? CNT_W : ordl_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_FIND,
        ST_REMOVE,
        ST_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W-1:0]                   ptr_reg, ptr_next;
    logic [ordl_pkg::DECK_W-1:0]        deck_reg, deck_next;
    logic [ordl_pkg::RANK_W-1:0]        rank_reg, rank_next;
    logic [ordl_pkg::GROUP_W-1:0]       grp_reg, grp_next;
    logic [ordl_pkg::ENTRY_W-1:0]       key_reg, key_next;
    logic [ordl_pkg::DECK_W-1:0]        deck_count_reg;

    logic [ordl_pkg::RANK_W-1:0]        res_rank_reg, res_rank_next;
    logic [ordl_pkg::GROUP_W-1:0]       res_group_reg, res_group_next;
    logic                               res_found_reg, res_found_next;
    logic [ordl_pkg::POS_W-1:0]         res_fpos_reg, res_fpos_next;
    logic                               res_err_reg, res_err_next;

    logic                               out_valid_reg, out_valid_next;
    logic [ordl_pkg::RANK_W-1:0]        out_rank_reg, out_rank_next;
    logic [ordl_pkg::GROUP_W-1:0]       out_group_reg, out_group_next;
    logic                               out_found_reg, out_found_next;
    logic [ordl_pkg::POS_W-1:0]         out_fpos_reg, out_fpos_next;
    logic [ordl_pkg::COUNT_W-1:0]       out_count_reg, out_count_next;
    logic                               out_err_reg, out_err_next;

    logic                               wr_en;
    logic [ADDR_W-1:0]                  wr_addr;
    logic [ordl_pkg::ENTRY_W-1:0]       wr_data;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [ordl_pkg::ENTRY_W-1:0]       rd_data;

    logic [CMP_W-1:0]                   pos_ext;
    logic                               pos_ok;
    logic [CNT_W-1:0]                   pos_cnt;
    logic [CNT_W-1:0]                   chk_idx;
    logic                               fill_last;
    logic                               out_free;

    ordl_ram #(
        .WIDTH (ordl_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // configuration
    assign pready = 1'b1;
    assign prdata = ordl_pkg::APB_DATA_W'(deck_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deck_count_reg <= ordl_pkg::DECK_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            deck_count_reg <= pwdata[ordl_pkg::DECK_W-1:0];
        end
    end

    assign cmd_in.ready           = (state_reg == ST_IDLE);
    assign res_out.valid          = out_valid_reg;
    assign res_out.out_rank       = out_rank_reg;
    assign res_out.out_group      = out_group_reg;
    assign res_out.found          = out_found_reg;
    assign res_out.found_position = out_fpos_reg;
    assign res_out.count_after    = out_count_reg;
    assign res_out.error          = out_err_reg;

    assign pos_ext   = CMP_W'(cmd_in.position);
    assign pos_ok    = pos_ext < CMP_W'(count_reg);
    assign pos_cnt   = CNT_W'(cmd_in.position);
    assign chk_idx   = ptr_reg - CNT_W'(1);
    assign out_free  = !out_valid_reg || res_out.ready;
    assign fill_last = (grp_reg == ordl_pkg::GROUP_W'(GROUPS - 1))
                    && (rank_reg == ordl_pkg::RANK_W'(RANKS_PER_GROUP))
                    && (deck_reg == deck_count_reg - ordl_pkg::DECK_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        deck_next      = deck_reg;
        rank_next      = rank_reg;
        grp_next       = grp_reg;
        key_next       = key_reg;
        res_rank_next  = res_rank_reg;
        res_group_next = res_group_reg;
        res_found_next = res_found_reg;
        res_fpos_next  = res_fpos_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_rank_next  = out_rank_reg;
        out_group_next = out_group_reg;
        out_found_next = out_found_reg;
        out_fpos_next  = out_fpos_reg;
        out_count_next = out_count_reg;
        out_err_next   = out_err_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = ordl_pkg::pack_entry(cmd_in.entry_rank, cmd_in.entry_group);
        rd_addr        = ptr_reg[ADDR_W-1:0];

        if (out_valid_reg && res_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_in.valid)
                begin
                    res_rank_next  = '0;
                    res_group_next = '0;
                    res_found_next = 1'b0;
                    res_fpos_next  = '0;
                    res_err_next   = 1'b0;
                    state_next     = ST_DONE;
                    unique case (ordl_pkg::command_t'(cmd_in.command))
                        ordl_pkg::CMD_FILL:
                        begin
                            deck_next = '0;
                            rank_next = ordl_pkg::RANK_W'(1);
                            grp_next  = '0;
                            ptr_next  = '0;
                            if (deck_count_reg == '0)
                            begin
                                count_next = '0;
                            end
                            else
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        ordl_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ordl_pkg::CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(CAPACITY))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_err_next = 1'b1;
                            end
                        end
                        ordl_pkg::CMD_READ:
                        begin
                            if (pos_ok)
                            begin
                                rd_addr    = pos_cnt[ADDR_W-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                res_err_next = 1'b1;
                            end
                        end
                        ordl_pkg::CMD_FIND:
                        begin
                            key_next = ordl_pkg::pack_entry(cmd_in.entry_rank,
                                                            cmd_in.entry_group);
                            if (count_reg != '0)
                            begin
                                rd_addr    = '0;
                                ptr_next   = CNT_W'(1);
                                state_next = ST_FIND;
                            end
                        end
                        ordl_pkg::CMD_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                res_err_next = 1'b1;
                            end
                            else if (pos_cnt + CNT_W'(1) == count_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                rd_addr    = ADDR_W'(pos_cnt + CNT_W'(1));
                                ptr_next   = pos_cnt + CNT_W'(2);
                                state_next = ST_REMOVE;
                            end
                        end
                        default:
                        begin
                            res_err_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (ptr_reg == CNT_W'(CAPACITY))
                begin
                    // entries still due but the list is full
                    res_err_next = 1'b1;
                    count_next   = ptr_reg;
                    state_next   = ST_DONE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_reg[ADDR_W-1:0];
                    wr_data  = ordl_pkg::pack_entry(rank_reg, grp_reg);
                    ptr_next = ptr_reg + CNT_W'(1);
                    if (fill_last)
                    begin
                        count_next = ptr_reg + CNT_W'(1);
                        state_next = ST_DONE;
                    end
                    else if (grp_reg == ordl_pkg::GROUP_W'(GROUPS - 1))
                    begin
                        grp_next = '0;
                        if (rank_reg == ordl_pkg::RANK_W'(RANKS_PER_GROUP))
                        begin
                            rank_next = ordl_pkg::RANK_W'(1);
                            deck_next = deck_reg + ordl_pkg::DECK_W'(1);
                        end
                        else
                        begin
                            rank_next = rank_reg + ordl_pkg::RANK_W'(1);
                        end
                    end
                    else
                    begin
                        grp_next = grp_reg + ordl_pkg::GROUP_W'(1);
                    end
                end
            end
            ST_READ:
            begin
                res_rank_next  = rd_data[ordl_pkg::RANK_W-1:0];
                res_group_next = rd_data[ordl_pkg::ENTRY_W-1:ordl_pkg::RANK_W];
                state_next     = ST_DONE;
            end
            ST_FIND:
            begin
                // rd_data holds the entry at chk_idx
                if (rd_data == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_fpos_next  = ordl_pkg::POS_W'(chk_idx);
                    state_next     = ST_DONE;
                end
                else if (ptr_reg == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            ST_REMOVE:
            begin
                // entry read last cycle moves down one place
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(ptr_reg - CNT_W'(2));
                wr_data = rd_data;
                if (ptr_reg == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rank_next  = res_rank_reg;
                    out_group_next = res_group_reg;
                    out_found_next = res_found_reg;
                    out_fpos_next  = res_fpos_reg;
                    out_count_next = ordl_pkg::COUNT_W'(count_reg);
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        deck_reg      <= deck_next;
        rank_reg      <= rank_next;
        grp_reg       <= grp_next;
        key_reg       <= key_next;
        res_rank_reg  <= res_rank_next;
        res_group_reg <= res_group_next;
        res_found_reg <= res_found_next;
        res_fpos_reg  <= res_fpos_next;
        res_err_reg   <= res_err_next;
        out_rank_reg  <= out_rank_next;
        out_group_reg <= out_group_next;
        out_found_reg <= out_found_next;
        out_fpos_reg  <= out_fpos_next;
        out_count_reg <= out_count_next;
        out_err_reg   <= out_err_next;
    end

endmodule

`default_nettype wire
